>>> hdl/rwcp_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk parser.
// No dependencies.
package rwcp_pkg;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_PAD,
        PH_STOP
    } t_phase;

    localparam logic [1:0]  FMT_NONE   = 2'd0;
    localparam logic [1:0]  FMT_PCM    = 2'd1;
    localparam logic [1:0]  FMT_EXT    = 2'd2;

    localparam logic [15:0] TAG_PCM    = 16'h0001;
    localparam logic [15:0] TAG_EXT    = 16'hFFFE;
    localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA    = 32'h6174_6164;
    localparam logic [31:0] FMT_MAX    = 32'd40;
    localparam int          STAGE_LEN  = 24;

    typedef logic [STAGE_LEN-1:0][7:0] t_stage;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] channel_mask;
    } t_fmt;

    typedef struct packed {
        logic        ok;
        t_fmt        fmt;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_result;

endpackage

>>> hdl/riff_wave_chunk_parser.sv
// Top level of the RIFF/WAVE chunk parser.
// Depends on rwcp_pkg, rwcp_parser and rwcp_out_reg.
//
// Usage:
//   Slave stream: one file byte per transfer on i_s_tdata, i_s_tlast on the
//   final byte of the file. Master stream: one summary per file.
//   One byte is taken every cycle while o_s_tready is high; the parser updates
//   its counters and captured fields in the same cycle the byte is transferred.
//   The summary appears on the master side in the cycle after the
//   transfer of the byte flagged tlast. The parser then returns to its
//   reset state, so the next file can start on the following cycle.
//   The result register holds one summary. While it is full and the
//   receiver stalls, o_s_tready is low; a byte is still taken in the cycle
//   the summary is transferred out.
//   Reset (i_rst_n low, synchronous) clears the parser and empties the
//   result register. No clearing pass is needed.
module riff_wave_chunk_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // file_byte
    input  logic         i_s_tlast,   // last_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // channels, sample_rate, avg_bytes_per_sec, block_align, bits_per_sample,
    // channel_mask, data_offset, data_size
    output logic [207:0] o_m_tdata,
    output logic [2:0]   o_m_tuser    // ok, format_kind
);
    import rwcp_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    rwcp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_s_tdata),
        .i_last         (i_s_tlast),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    rwcp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (out_res)
    );

    assign o_m_tdata = {out_res.data_size,
                        out_res.data_offset,
                        out_res.fmt.channel_mask,
                        out_res.fmt.bits_per_sample,
                        out_res.fmt.block_align,
                        out_res.fmt.avg_bytes_per_sec,
                        out_res.fmt.sample_rate,
                        out_res.fmt.channels};
    assign o_m_tuser = {out_res.fmt.kind, out_res.ok};

endmodule

>>> hdl/rwcp_parser.sv
// Byte-wise chunk walker: RIFF header, chunk headers, fmt capture, skipping.
// Depends on rwcp_pkg.
module rwcp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_result_valid,
    output rwcp_pkg::t_result   o_result
);
    import rwcp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [3:0]  r_hidx, n_hidx;
    logic [31:0] r_riff_size, n_riff_size;
    logic [31:0] r_chunk_id, n_chunk_id;
    logic [31:0] r_chunk_size, n_chunk_size;
    logic [31:0] r_bytes_left, n_bytes_left;
    t_stage      r_stage, n_stage;
    logic [5:0]  r_fmt_idx, n_fmt_idx;
    t_fmt        r_fmt, n_fmt;
    logic [31:0] r_data_off, n_data_off;
    logic [31:0] r_data_size, n_data_size;

    function automatic t_fmt decode_fmt(input t_stage s);
        t_fmt        f;
        logic [15:0] tag;
        tag                 = {s[1], s[0]};
        f.kind              = (tag == TAG_PCM) ? FMT_PCM : FMT_EXT;
        f.channels          = {s[3], s[2]};
        f.sample_rate       = {s[7], s[6], s[5], s[4]};
        f.avg_bytes_per_sec = {s[11], s[10], s[9], s[8]};
        f.block_align       = {s[13], s[12]};
        f.bits_per_sample   = {s[15], s[14]};
        f.channel_mask      = (tag == TAG_EXT) ? {s[23], s[22], s[21], s[20]} : 32'd0;
        return f;
    endfunction

    function automatic logic fmt_tag_ok(input t_stage s);
        return ({s[1], s[0]} == TAG_PCM) || ({s[1], s[0]} == TAG_EXT);
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos + 32'd1;
        n_hidx       = r_hidx;
        n_riff_size  = r_riff_size;
        n_chunk_id   = r_chunk_id;
        n_chunk_size = r_chunk_size;
        n_bytes_left = r_bytes_left;
        n_stage      = r_stage;
        n_fmt_idx    = r_fmt_idx;
        n_fmt        = r_fmt;
        n_data_off   = r_data_off;
        n_data_size  = r_data_size;

        case (r_phase)
            PH_RIFF: begin
                if (r_hidx >= 4'd4 && r_hidx < 4'd8) begin
                    n_riff_size = {i_byte, r_riff_size[31:8]};
                end
                n_hidx = r_hidx + 4'd1;
                if (r_hidx == 4'd11) begin
                    n_hidx  = 4'd0;
                    n_phase = (n_riff_size != 32'd0) ? PH_HDR : PH_STOP;
                end
            end
            PH_HDR: begin
                if (r_hidx < 4'd4) begin
                    n_chunk_id = {i_byte, r_chunk_id[31:8]};
                end else begin
                    n_chunk_size = {i_byte, r_chunk_size[31:8]};
                end
                n_hidx = r_hidx + 4'd1;
                if (r_hidx == 4'd7) begin
                    n_hidx = 4'd0;
                    if (n_chunk_id == ID_FMT && n_chunk_size <= FMT_MAX) begin
                        n_stage   = '0;
                        n_fmt_idx = 6'd0;
                        if (n_chunk_size == 32'd0) begin
                            n_phase = n_chunk_size[0] ? PH_PAD : PH_HDR;
                        end else begin
                            n_bytes_left = n_chunk_size;
                            n_phase      = PH_FMT;
                        end
                    end else begin
                        if (n_chunk_id == ID_DATA) begin
                            n_data_size = n_chunk_size;
                            n_data_off  = n_pos;
                        end
                        if (n_chunk_size == 32'd0) begin
                            n_phase = n_chunk_size[0] ? PH_PAD : PH_HDR;
                        end else begin
                            n_bytes_left = n_chunk_size;
                            n_phase      = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT: begin
                for (int k = 0; k < STAGE_LEN; k++) begin
                    if (r_fmt_idx == 6'(k)) begin
                        n_stage[k] = i_byte;
                    end
                end
                n_fmt_idx    = r_fmt_idx + 6'd1;
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    if (fmt_tag_ok(n_stage)) begin
                        n_fmt = decode_fmt(n_stage);
                    end
                    n_phase = r_chunk_size[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_SKIP: begin
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    n_phase = r_chunk_size[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_PAD: begin
                n_phase = PH_HDR;
            end
            default: begin
            end
        endcase

        o_result_valid       = i_accept && i_last;
        o_result.ok          = (n_data_size != 32'd0) && (n_data_off != 32'd0);
        o_result.fmt         = n_fmt;
        o_result.data_offset = n_data_off;
        o_result.data_size   = n_data_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase      <= PH_RIFF;
            r_pos        <= '0;
            r_hidx       <= '0;
            r_riff_size  <= '0;
            r_chunk_id   <= '0;
            r_chunk_size <= '0;
            r_bytes_left <= '0;
            r_fmt_idx    <= '0;
            r_fmt        <= '0;
            r_data_off   <= '0;
            r_data_size  <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_hidx       <= n_hidx;
            r_riff_size  <= n_riff_size;
            r_chunk_id   <= n_chunk_id;
            r_chunk_size <= n_chunk_size;
            r_bytes_left <= n_bytes_left;
            r_fmt_idx    <= n_fmt_idx;
            r_fmt        <= n_fmt;
            r_data_off   <= n_data_off;
            r_data_size  <= n_data_size;
        end
    end

    // staging is cleared at the start of every fmt chunk that is captured, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stage <= n_stage;
        end
    end

endmodule

>>> hdl/rwcp_out_reg.sv
// Result register between the parser and the master stream.
// Depends on rwcp_pkg.
module rwcp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rwcp_pkg::t_result   i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output rwcp_pkg::t_result   o_result
);
    import rwcp_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hdl/rwcp_checker.sv
// Port-level checks for the RIFF/WAVE chunk parser, bound to the top level.
// Depends on riff_wave_chunk_parser.
module rwcp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         i_s_tlast,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [207:0] o_m_tdata,
    input logic [2:0]   o_m_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("summary changed while stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("no summary after final byte");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !$past(o_m_tvalid && !i_m_tready)
            |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("summary without a final byte");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0]
            |-> (o_m_tdata[207:176] != 32'd0) && (o_m_tdata[175:144] != 32'd0))
        else $error("ok set with empty data chunk");

    a_none_zero_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[2:1] == 2'd0) |-> (o_m_tdata[143:0] == 144'd0))
        else $error("format fields set with no format found");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
